/* rtl/core/rpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the repeating pattern detector.
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int SYMBOL_W = 16;
    localparam int COUNT_W  = 8;
    localparam int LENGTH_W = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_GATHER = 2'd0,
        MODE_SYNC   = 2'd1,
        MODE_CHECK  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  repeat_count;
        logic [LENGTH_W-1:0] pattern_length;
        mode_t               mode;
        logic                overflow;
    } rpd_result_t;

endpackage

/* rtl/core/rpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_if
// Valid/ready channels of the detector: symbol input, result output and
// anchor write port.
// ----------------------------------------------------------------------------
interface rpd_sym_if;
    logic                         valid;
    logic                         ready;
    logic [rpd_pkg::SYMBOL_W-1:0] symbol_id;

    modport source (output valid, output symbol_id, input ready);
    modport sink   (input valid, input symbol_id, output ready);
endinterface

interface rpd_res_if;
    logic                         valid;
    logic                         ready;
    logic [rpd_pkg::COUNT_W-1:0]  repeat_count;
    logic [rpd_pkg::LENGTH_W-1:0] pattern_length;
    rpd_pkg::mode_t               mode;
    logic                         overflow;

    modport source (output valid, output repeat_count, output pattern_length,
                    output mode, output overflow, input ready);
    modport sink   (input valid, input repeat_count, input pattern_length,
                    input mode, input overflow, output ready);
endinterface

interface rpd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rpd_pkg::SYMBOL_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/repeating_pattern_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_pattern_detector
// Tracks back-to-back repetitions of an anchor-led pattern in a symbol
// stream and reports count, length, mode and overflow for every symbol.
// ----------------------------------------------------------------------------
// The result of an accepted symbol beat is registered in the output buffer.
// Throughput: one symbol per cycle while skid is free, set by updating mode,
//   position and length with the pattern entry prefetched from the store.
// A two-entry output buffer keeps input open while one result waits.
// Reset: mode gathering, length 1, count 1, anchor 0; the store needs no
//   clearing pass, so symbols are taken right after reset.
module repeating_pattern_detector #(
    parameter int MAX_PATTERN = rpd_pkg::MAX_PATTERN_DEF,
    parameter int ID_BITS     = rpd_pkg::ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rpd_sym_if.sink   sym,
    rpd_res_if.source res,
    rpd_cfg_if.sink   cfg
);

    logic                 buf_ready;
    logic                 fire;
    rpd_pkg::rpd_result_t core_result;

    // Anchor writes are always taken
    assign cfg.ready = 1'b1;
    assign sym.ready = buf_ready;
    assign fire      = sym.valid && buf_ready;

    rpd_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .ID_BITS     (ID_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.data),
        .fire      (fire),
        .symbol_id (sym.symbol_id),
        .result    (core_result)
    );

    rpd_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_data  (core_result),
        .push_ready (buf_ready),
        .res        (res)
    );

endmodule

/* rtl/core/rpd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_core
// Mode sequencer, pattern store and compare datapath. Updates the state for
// one symbol per cycle while fire is high and produces that beat's result.
// ----------------------------------------------------------------------------
module rpd_core #(
    parameter int MAX_PATTERN = rpd_pkg::MAX_PATTERN_DEF,
    parameter int ID_BITS     = rpd_pkg::ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rpd_pkg::SYMBOL_W-1:0] cfg_data,
    input  logic                         fire,
    input  logic [rpd_pkg::SYMBOL_W-1:0] symbol_id,
    output rpd_pkg::rpd_result_t         result
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int CMP_W = (ID_BITS < rpd_pkg::SYMBOL_W) ? ID_BITS : rpd_pkg::SYMBOL_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    rpd_pkg::mode_t              mode_reg, mode_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [rpd_pkg::COUNT_W-1:0] repeat_reg, repeat_next;
    logic [CMP_W-1:0]            anchor_reg;
    logic [CMP_W-1:0]            exp_reg;
    logic [CMP_W-1:0]            store [MAX_PATTERN];

    logic [CMP_W-1:0] sym_c;
    logic [CMP_W-1:0] expected;
    logic [IDX_W-1:0] pos_eff;
    logic [LEN_W-1:0] pos_inc;
    logic [IDX_W-1:0] rd_addr;
    logic             is_anchor;
    logic             match;
    logic             wrap;
    logic             store_full;
    logic             wr_en;
    logic             dropped;

    // Compare on the low identifier bits only
    assign sym_c      = symbol_id[CMP_W-1:0];
    assign is_anchor  = (sym_c == anchor_reg);
    assign store_full = (len_reg >= LEN_MAX);

    // Pick the expected entry; position zero always expects the anchor
    assign pos_eff  = (LEN_W'(pos_reg) < len_reg) ? pos_reg : '0;
    assign expected = (pos_eff == '0) ? anchor_reg : exp_reg;
    assign match    = (expected == sym_c);
    assign pos_inc  = LEN_W'(pos_eff) + LEN_ONE;
    assign wrap     = (pos_inc >= len_reg);

    // Next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (fire)
        begin
            unique case (mode_reg)
                rpd_pkg::MODE_SYNC:
                begin
                    if (is_anchor)
                        mode_next = rpd_pkg::MODE_GATHER;
                end
                rpd_pkg::MODE_GATHER:
                begin
                    if (is_anchor)
                        mode_next = rpd_pkg::MODE_CHECK;
                end
                rpd_pkg::MODE_CHECK:
                begin
                    if (!match)
                        mode_next = is_anchor ? rpd_pkg::MODE_GATHER : rpd_pkg::MODE_SYNC;
                end
                default: mode_next = rpd_pkg::MODE_GATHER;
            endcase
        end
    end

    // Length, position, count and store write for this beat
    always_comb
    begin
        len_next    = len_reg;
        pos_next    = pos_reg;
        repeat_next = repeat_reg;
        wr_en       = 1'b0;
        dropped     = 1'b0;
        if (fire)
        begin
            unique case (mode_reg)
                rpd_pkg::MODE_SYNC:
                begin
                    len_next = len_reg;
                end
                rpd_pkg::MODE_GATHER:
                begin
                    if (!is_anchor)
                    begin
                        if (!store_full)
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_ONE;
                        end
                        else
                            dropped = 1'b1;
                    end
                    else
                    begin
                        pos_next    = (len_reg == LEN_ONE) ? IDX_W'(0) : IDX_W'(1);
                        repeat_next = rpd_pkg::COUNT_W'(2);
                    end
                end
                rpd_pkg::MODE_CHECK:
                begin
                    if (match)
                    begin
                        if (wrap)
                        begin
                            pos_next = '0;
                            if (repeat_reg < rpd_pkg::COUNT_MAX)
                                repeat_next = repeat_reg + rpd_pkg::COUNT_W'(1);
                        end
                        else
                            pos_next = pos_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        pos_next    = pos_eff;
                        repeat_next = '0;
                        len_next    = LEN_ONE;
                    end
                end
                default: len_next = len_reg;
            endcase
        end
    end

    // Prefetch the entry for the next compare
    assign rd_addr = fire ? pos_next : pos_reg;

    // Drive the beat's result
    always_comb
    begin
        result.repeat_count   = repeat_next;
        result.pattern_length = rpd_pkg::LENGTH_W'(len_next);
        result.mode           = mode_next;
        result.overflow       = dropped;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= rpd_pkg::MODE_GATHER;
            len_reg    <= LEN_ONE;
            pos_reg    <= '0;
            repeat_reg <= rpd_pkg::COUNT_W'(1);
            anchor_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            repeat_reg <= repeat_next;
            if (cfg_we)
                anchor_reg <= cfg_data[CMP_W-1:0];
        end
    end

    // Pattern store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[len_reg[IDX_W-1:0]] <= sym_c;
        exp_reg <= store[rd_addr];
    end

endmodule

/* rtl/core/rpd_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_outbuf
// Two-entry output buffer: result register plus skid register, so a new
// beat is taken while a finished result waits downstream.
// ----------------------------------------------------------------------------
module rpd_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rpd_pkg::rpd_result_t push_data,
    output logic                 push_ready,
    rpd_res_if.source            res
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    rpd_pkg::rpd_result_t main_reg;
    rpd_pkg::rpd_result_t skid_reg;
    logic                 pop;

    assign push_ready = !skid_valid_reg;
    assign pop        = main_valid_reg && res.ready;

    // Present the head entry
    assign res.valid          = main_valid_reg;
    assign res.repeat_count   = main_reg.repeat_count;
    assign res.pattern_length = main_reg.pattern_length;
    assign res.mode           = main_reg.mode;
    assign res.overflow       = main_reg.overflow;

    // Advance head from skid or input; park input in skid on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Payload moves without reset
    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
            skid_reg <= push_data;
    end

endmodule

/* rtl/core/rpd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks on the detector's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rpd_checker #(
    parameter int MAX_PATTERN = rpd_pkg::MAX_PATTERN_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rpd_pkg::COUNT_W-1:0]  repeat_count,
    input logic [rpd_pkg::LENGTH_W-1:0] pattern_length,
    input rpd_pkg::mode_t               mode,
    input logic                         overflow
);

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(repeat_count)
            && $stable(pattern_length) && $stable(mode) && $stable(overflow))
        else $error("result beat changed while stalled");

    // Drop only from a full store while gathering
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> mode == rpd_pkg::MODE_GATHER
            && pattern_length == rpd_pkg::LENGTH_W'(MAX_PATTERN))
        else $error("overflow outside a full gathering store");

    // Synchronizing keeps the pattern cut back and the count cleared
    a_sync_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == rpd_pkg::MODE_SYNC |->
            repeat_count == '0 && pattern_length == rpd_pkg::LENGTH_W'(1))
        else $error("synchronizing with live pattern or count");

    // Checking starts at a count of two and never drops below
    a_check_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == rpd_pkg::MODE_CHECK |-> repeat_count >= rpd_pkg::COUNT_W'(2))
        else $error("checking with a count below two");

endmodule

bind repeating_pattern_detector rpd_checker #(
    .MAX_PATTERN (MAX_PATTERN)
) u_rpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .repeat_count   (res.repeat_count),
    .pattern_length (res.pattern_length),
    .mode           (res.mode),
    .overflow       (res.overflow)
);
